[rtl/utf8_kana_case_folder_macros.svh]
// Assertion macros used by the checker file of the kana case folder.
// Depends on nothing; users supply clock and reset signals in scope.
`ifndef UTF8_KANA_CASE_FOLDER_MACROS_SVH
`define UTF8_KANA_CASE_FOLDER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define UKCF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ukcf check failed");

// Check a property on every clock edge, reset included.
`define UKCF_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("ukcf check failed");

`endif

[rtl/ukcf_pkg.sv]
// Shared types and constants of the kana case folder.
// Depends on nothing; used by the front, queue, back and top level.
package ukcf_pkg;

   // Code point bounds of the kana and ASCII ranges, and the kana shift
   localparam logic [20:0] KATA_LO    = 21'h030A1;
   localparam logic [20:0] KATA_HI    = 21'h030F6;
   localparam logic [20:0] KANA_SHIFT = 21'h00060;
   localparam logic [20:0] HIRA_LO    = 21'h03041;
   localparam logic [20:0] HIRA_HI    = 21'h03096;
   localparam logic [20:0] ASCII_TOP  = 21'h00080;

   // Byte constants of the encoding
   localparam logic [7:0] HIRA_LEAD  = 8'hE3;
   localparam logic [1:0] CONT_TAG   = 2'b10;

   // Up to four output bytes caused by one input item
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic            done;
   } burst_type;

endpackage

[rtl/ukcf_front.sv]
// Front end: accepts input bytes, runs the UTF-8 gather/decode state and
// builds at most one burst of output bytes per item. Depends on ukcf_pkg.
module ukcf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                end_of_text,
   output logic                push,
   output ukcf_pkg::burst_type push_data
);

   logic [7:0]  pend_ff [3];
   logic [7:0]  pend_in [3];
   logic [1:0]  cnt_ff, cnt_in;
   logic [2:0]  len_ff, len_in;
   logic [20:0] code_ff, code_in;

   logic [3:0][7:0] obytes;
   logic [2:0]      n;
   logic            fresh;
   logic [20:0]     code_acc;
   logic [20:0]     cp;

   function automatic logic [7:0] fold_ascii(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h41:8'h5A]}) r = c + 8'd32;
      return r;
   endfunction

   // Decode the byte against the pending sequence and list the output bytes
   always_comb begin
      pend_in  = pend_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      code_in  = code_ff;
      obytes   = '0;
      n        = 3'd0;
      fresh    = 1'b0;
      code_acc = {code_ff[14:0], in_byte[5:0]};
      cp       = code_acc;

      if (cnt_ff == 2'd0) begin
         fresh = 1'b1;
      end else if (in_byte[7:6] == ukcf_pkg::CONT_TAG) begin
         if ((({1'b0, cnt_ff} + 3'd1) >= len_ff) || (cnt_ff == 2'd3)) begin
            // complete the sequence
            if (code_acc inside {[ukcf_pkg::KATA_LO:ukcf_pkg::KATA_HI]})
               cp = code_acc - ukcf_pkg::KANA_SHIFT;
            if (cp inside {[ukcf_pkg::HIRA_LO:ukcf_pkg::HIRA_HI]}) begin
               obytes[0] = ukcf_pkg::HIRA_LEAD;
               obytes[1] = {ukcf_pkg::CONT_TAG, cp[11:6]};
               obytes[2] = {ukcf_pkg::CONT_TAG, cp[5:0]};
               n = 3'd3;
            end else if (cp < ukcf_pkg::ASCII_TOP) begin
               obytes[0] = fold_ascii(cp[7:0]);
               n = 3'd1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < cnt_ff) obytes[i] = pend_ff[i];
               end
               obytes[cnt_ff] = in_byte;
               n = {1'b0, cnt_ff} + 3'd1;
            end
            cnt_in  = 2'd0;
            len_in  = 3'd0;
            code_in = '0;
         end else begin
            // buffer the continuation byte
            pend_in[cnt_ff] = in_byte;
            cnt_in  = cnt_ff + 2'd1;
            code_in = code_acc;
         end
      end else begin
         // bad continuation: drop the pending bytes out raw, restart
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < cnt_ff) obytes[i] = pend_ff[i];
         end
         n       = {1'b0, cnt_ff};
         cnt_in  = 2'd0;
         len_in  = 3'd0;
         code_in = '0;
         fresh   = 1'b1;
      end

      // handle the byte as the start of something new
      if (fresh) begin
         if (in_byte inside {[8'h00:8'h7F]}) begin
            obytes[n[1:0]] = fold_ascii(in_byte);
            n = n + 3'd1;
         end else if (in_byte inside {[8'hC0:8'hDF]}) begin
            pend_in[0] = in_byte;
            cnt_in  = 2'd1;
            len_in  = 3'd2;
            code_in = {16'b0, in_byte[4:0]};
         end else if (in_byte inside {[8'hE0:8'hEF]}) begin
            pend_in[0] = in_byte;
            cnt_in  = 2'd1;
            len_in  = 3'd3;
            code_in = {17'b0, in_byte[3:0]};
         end else if (in_byte inside {[8'hF0:8'hF7]}) begin
            pend_in[0] = in_byte;
            cnt_in  = 2'd1;
            len_in  = 3'd4;
            code_in = {18'b0, in_byte[2:0]};
         end else begin
            obytes[n[1:0]] = in_byte;
            n = n + 3'd1;
         end
      end

      // flush whatever is still pending at the end of the text
      if (end_of_text && (cnt_in != 2'd0)) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < cnt_in) begin
               obytes[n[1:0]] = pend_in[i];
               n = n + 3'd1;
            end
         end
         cnt_in  = 2'd0;
         len_in  = 3'd0;
         code_in = '0;
      end
   end

   assign push               = accept && (n != 3'd0);
   assign push_data.data     = obytes;
   assign push_data.last_idx = 2'(n - 3'd1);
   assign push_data.done     = end_of_text;

   // Advance the decode state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         len_ff  <= 3'd0;
         code_ff <= '0;
      end else if (accept) begin
         cnt_ff  <= cnt_in;
         len_ff  <= len_in;
         code_ff <= code_in;
      end
   end

   // Hold the buffered bytes; only written entries are ever read
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

[rtl/ukcf_queue.sv]
// Burst queue between the front end and the output serializer.
// Depends on ukcf_pkg for the burst type.
module ukcf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ukcf_pkg::burst_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output ukcf_pkg::burst_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ukcf_pkg::burst_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         if (push && !pop)
            count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push)
            count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Store pushed bursts
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/ukcf_back.sv]
// Output serializer: walks the head burst one byte per cycle, while the
// result is not stalled, into the result register. Depends on ukcf_pkg.
module ukcf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  ukcf_pkg::burst_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run,
   output logic                rsp_text_done
);

   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff, done_ff;
   logic [1:0] sel_ff, sel_in;
   logic       load, at_last;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign at_last = (sel_ff == head.last_idx);
   assign pop     = load && at_last;
   assign sel_in  = at_last ? 2'd0 : sel_ff + 2'd1;

   // Advance the byte select and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            sel_ff   <= sel_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Load the next result byte
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head.data[sel_ff];
         last_ff <= at_last;
         done_ff <= at_last && head.done;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_text_done   = done_ff;

endmodule

[rtl/utf8_kana_case_folder.sv]
// UTF-8 folder: katakana becomes hiragana, ASCII A-Z becomes a-z, and all
// other bytes pass as written, but overlong forms of ASCII and kana are
// shortened. One input byte is accepted per cycle while the burst queue has
// room; each byte yields zero to four result bytes, and the output serializer
// delivers one result byte per cycle while rsp_stall is low. A byte with
// several results holds the serializer; QUEUE_DEPTH bursts absorb that before
// req_stall rises. Results are registered in the queue, then the result register.
module utf8_kana_case_folder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_text_done
);

   logic                accept;
   logic                push, pop, full, head_valid;
   ukcf_pkg::burst_type push_data, head;

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   // Decode and build bursts
   ukcf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .push        (push),
      .push_data   (push_data)
   );

   // Decouple decode from output
   ukcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   // Serialize bursts into result bytes
   ukcf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_text_done   (rsp_text_done)
   );

endmodule

[rtl/ukcf_checker.sv]
// Port-level checks for the kana case folder, bound to the top level.
// Depends on utf8_kana_case_folder_macros.svh.
`include "utf8_kana_case_folder_macros.svh"

module ukcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       req_end_of_text,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic       rsp_text_done
);

   // Hold a stalled input item
   `UKCF_ASSERT(a_req_hold, req_valid && req_stall |=> req_valid && $stable(req_in_byte))
   // Hold a stalled result item
   `UKCF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte))
   // End of text is always the last byte of its run
   `UKCF_ASSERT(a_done_last, rsp_valid && rsp_text_done |-> rsp_last_of_run)
   // Output is empty right after reset
   `UKCF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)
   // An end-of-text item accepted while idle passes the queue into a result
   `UKCF_ASSERT(a_eot_result, req_valid && !req_stall && req_end_of_text && !rsp_valid |=> ##1 rsp_valid)

endmodule

bind utf8_kana_case_folder ukcf_checker u_ukcf_checker (.*);
